FILE: sv/poly_voice_allocator_unit_macros.svh
// ------------------------------------------------------------------------
// poly_voice_allocator_unit assertion macros
// Shared concurrent assertion forms for the voice allocator RTL.
// ------------------------------------------------------------------------
`ifndef POLY_VOICE_ALLOCATOR_UNIT_MACROS_SVH
`define POLY_VOICE_ALLOCATOR_UNIT_MACROS_SVH

// same-cycle implication, held off during reset
`define PVA_ASSERT_HOLDS(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off during reset
`define PVA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/pva_pkg.sv
// ------------------------------------------------------------------------
// pva_pkg
// Types, codes and sizes shared by the polyphonic voice allocator.
// ------------------------------------------------------------------------
package pva_pkg;

    localparam int MAX_VOICES  = 16;
    localparam int VOICE_W     = $clog2(MAX_VOICES);
    localparam int AGE_BITS    = 16;
    localparam int NOTE_W      = 7;
    localparam int VEL_W       = 7;
    localparam int HELD_W      = NOTE_W + 1;
    localparam int CMD_W       = 2;
    localparam int ACTIVE_W    = 5;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [HELD_W-1:0]   NO_NOTE = HELD_W'(128);
    localparam logic [AGE_BITS-1:0] AGE_MAX = '1;

    localparam logic [CMD_W-1:0] CMD_NOTE   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FINISH = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TICK   = 2'd2;

    typedef enum logic [2:0] {
        ACT_NONE    = 3'd0,
        ACT_START   = 3'd1,
        ACT_RELEASE = 3'd2,
        ACT_RETRIG  = 3'd3,
        ACT_STEAL   = 3'd4
    } action_t;

    typedef enum logic [1:0] {
        OP_NOTE_ON  = 2'd0,
        OP_NOTE_OFF = 2'd1,
        OP_FINISH   = 2'd2,
        OP_TICK     = 2'd3
    } op_t;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [NOTE_W-1:0]  note;
        logic [VEL_W-1:0]   velocity;
        logic [VOICE_W-1:0] finished_voice;
    } in_item_t;

    typedef struct packed {
        logic [VOICE_W-1:0] voice;
        action_t            action;
        logic [NOTE_W-1:0]  out_note;
        logic [VEL_W-1:0]   out_velocity;
        logic               reset_modulators;
        logic               last;
    } result_t;

    // classified job passed from front to back
    typedef struct packed {
        op_t                op;
        logic [NOTE_W-1:0]  note;
        logic [VEL_W-1:0]   velocity;
        logic [VOICE_W-1:0] voice;
    } job_t;

    typedef struct packed {
        logic not_empty;
        logic full;
    } q_status_t;

endpackage

FILE: sv/poly_voice_allocator_unit.sv
// ------------------------------------------------------------------------
// poly_voice_allocator_unit
// Polyphonic voice allocator with oldest-voice stealing.
// ------------------------------------------------------------------------
// A command beat is taken when start is high and busy is low. Finish and
// tick beats are carried out in the back end as they leave the queue. A
// note beat scans the active voices one per cycle after it leaves the
// queue, having passed through the front register and the queue first. A
// note-on ends early at the first matching or idle voice. The back end
// takes no new job from the queue until a note job has given its final
// result. The two-entry queue lets the front keep taking beats while a
// scan runs. Results appear on result for exactly one cycle, marked by
// strobe, and cannot be held off. A note-off gives one result per released
// voice, in voice order and at most one per cycle, with last set on the
// final one, or a single ACT_NONE result with last set when no active
// voice holds the note.
// ------------------------------------------------------------------------
module poly_voice_allocator_unit (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  pva_pkg::in_item_t      item,
    output logic                   busy,
    output pva_pkg::result_t       result,
    output logic                   strobe,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [2:0]             paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    localparam int AW = pva_pkg::ACTIVE_W;
    localparam logic [AW-1:0] VOICES_MAX = AW'(pva_pkg::MAX_VOICES);

    logic [AW-1:0]               active_reg, active_next;
    logic [AW-1:0]               vcount;
    logic [pva_pkg::VOICE_W-1:0] last_idx;
    logic                        reg_sel;
    logic                        push;
    logic                        q_pop;
    pva_pkg::job_t               fr_job;
    pva_pkg::job_t               q_job;
    pva_pkg::q_status_t          q_st;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[2] == 1'b0);
    assign prdata  = reg_sel ? {{(32-AW){1'b0}}, active_reg} : '0;

    always_comb
    begin
        active_next = active_reg;
        if (psel && penable && pwrite && reg_sel)
        begin
            active_next = pwdata[AW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= VOICES_MAX;
        end
        else
        begin
            active_reg <= active_next;
        end
    end

    // clamp the register into 1..MAX_VOICES
    always_comb
    begin
        if (active_reg == '0)
        begin
            vcount = AW'(1);
        end
        else if (active_reg > VOICES_MAX)
        begin
            vcount = VOICES_MAX;
        end
        else
        begin
            vcount = active_reg;
        end
    end

    assign last_idx = pva_pkg::VOICE_W'(vcount - 1'b1);

    pva_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .item  (item),
        .busy  (busy),
        .q_st  (q_st),
        .push  (push),
        .job   (fr_job)
    );

    pva_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .job_in  (fr_job),
        .pop     (q_pop),
        .job_out (q_job),
        .q_st    (q_st)
    );

    pva_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_st     (q_st),
        .q_job    (q_job),
        .q_pop    (q_pop),
        .last_idx (last_idx),
        .result   (result),
        .strobe   (strobe)
    );

endmodule

FILE: sv/pva_front.sv
// ------------------------------------------------------------------------
// pva_front
// Accepts command beats, classifies them and hands jobs to the queue.
// ------------------------------------------------------------------------
module pva_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  pva_pkg::in_item_t   item,
    output logic                busy,
    input  pva_pkg::q_status_t  q_st,
    output logic                push,
    output pva_pkg::job_t       job
);

    logic          fr_valid_reg, fr_valid_next;
    pva_pkg::job_t fr_job_reg, fr_job_next;
    logic          accept;
    logic          keep;
    pva_pkg::op_t  op;

    assign busy   = fr_valid_reg & q_st.full;
    assign push   = fr_valid_reg & ~q_st.full;
    assign job    = fr_job_reg;
    assign accept = start & ~busy;

    always_comb
    begin
        keep = 1'b1;
        op   = pva_pkg::OP_TICK;
        unique case (item.cmd)
            pva_pkg::CMD_NOTE:
            begin
                op = (item.velocity == '0) ? pva_pkg::OP_NOTE_OFF : pva_pkg::OP_NOTE_ON;
            end
            pva_pkg::CMD_FINISH: op = pva_pkg::OP_FINISH;
            pva_pkg::CMD_TICK:   op = pva_pkg::OP_TICK;
            default:             keep = 1'b0;   // unused command, dropped
        endcase
    end

    always_comb
    begin
        fr_valid_next = fr_valid_reg & q_st.full;
        fr_job_next   = fr_job_reg;
        if (accept)
        begin
            fr_valid_next        = keep;
            fr_job_next.op       = op;
            fr_job_next.note     = item.note;
            fr_job_next.velocity = item.velocity;
            fr_job_next.voice    = item.finished_voice;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fr_valid_reg <= 1'b0;
        end
        else
        begin
            fr_valid_reg <= fr_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fr_job_reg <= fr_job_next;
    end

endmodule

FILE: sv/pva_queue.sv
// ------------------------------------------------------------------------
// pva_queue
// Short job FIFO decoupling the front from the back.
// ------------------------------------------------------------------------
module pva_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  pva_pkg::job_t      job_in,
    input  logic               pop,
    output pva_pkg::job_t      job_out,
    output pva_pkg::q_status_t q_st
);

    localparam int PTR_W = (pva_pkg::QUEUE_DEPTH > 1) ? $clog2(pva_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(pva_pkg::QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(pva_pkg::QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(pva_pkg::QUEUE_DEPTH);

    pva_pkg::job_t    entry_reg [pva_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign q_st.not_empty = (count_reg != '0);
    assign q_st.full      = (count_reg == CNT_FULL);
    assign job_out        = entry_reg[rd_ptr_reg];
    assign do_push        = push & ~q_st.full;
    assign do_pop         = pop & q_st.not_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= job_in;
        end
    end

endmodule

FILE: sv/pva_back.sv
// ------------------------------------------------------------------------
// pva_back
// Voice table and the scanning sequencer that carries out queued jobs.
// ------------------------------------------------------------------------
`include "poly_voice_allocator_unit_macros.svh"

module pva_back (
    input  logic                                clk,
    input  logic                                rst_n,
    input  pva_pkg::q_status_t                  q_st,
    input  pva_pkg::job_t                       q_job,
    output logic                                q_pop,
    input  logic [pva_pkg::VOICE_W-1:0]         last_idx,
    output pva_pkg::result_t                    result,
    output logic                                strobe
);

    localparam int VW = pva_pkg::VOICE_W;
    localparam int NV = pva_pkg::MAX_VOICES;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t                          state_reg, state_next;
    pva_pkg::job_t                   job_reg, job_next;
    logic [VW-1:0]                   idx_reg, idx_next;
    logic [VW-1:0]                   oldest_reg, oldest_next;
    logic [pva_pkg::AGE_BITS-1:0]    oldest_age_reg, oldest_age_next;
    logic                            pend_valid_reg, pend_valid_next;
    logic [VW-1:0]                   pend_reg, pend_next;
    logic                            rst_mod_reg, rst_mod_next;
    logic [pva_pkg::HELD_W-1:0]      held_reg [NV];
    logic [pva_pkg::HELD_W-1:0]      held_next [NV];
    logic [NV-1:0]                   sounding_reg, sounding_next;
    logic [pva_pkg::AGE_BITS-1:0]    age_reg [NV];
    logic [pva_pkg::AGE_BITS-1:0]    age_next [NV];
    pva_pkg::result_t                result_reg, result_next;
    logic                            strobe_reg, strobe_next;

    logic [NV-1:0]                   active_mask;
    logic                            playing;
    logic [pva_pkg::HELD_W-1:0]      cur_held;
    logic                            cur_snd;
    logic [pva_pkg::AGE_BITS-1:0]    cur_age;
    logic                            hit;
    logic                            at_end;
    logic                            take_en;
    logic [VW-1:0]                   take_idx;

    assign result = result_reg;
    assign strobe = strobe_reg;

    always_comb
    begin
        for (int i = 0; i < NV; i++)
        begin
            active_mask[i] = (VW'(i) <= last_idx);
        end
    end

    assign playing  = |(sounding_reg & active_mask);
    assign cur_held = held_reg[idx_reg];
    assign cur_snd  = sounding_reg[idx_reg];
    assign cur_age  = age_reg[idx_reg];
    assign hit      = (cur_held == {1'b0, job_reg.note});
    assign at_end   = (idx_reg == last_idx);

    always_comb
    begin
        state_next      = state_reg;
        job_next        = job_reg;
        idx_next        = idx_reg;
        oldest_next     = oldest_reg;
        oldest_age_next = oldest_age_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        rst_mod_next    = rst_mod_reg;
        held_next       = held_reg;
        sounding_next   = sounding_reg;
        age_next        = age_reg;
        result_next     = result_reg;
        strobe_next     = 1'b0;
        q_pop           = 1'b0;
        take_en         = 1'b0;
        take_idx        = idx_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_st.not_empty)
                begin
                    q_pop = 1'b1;
                    case (q_job.op)
                        pva_pkg::OP_FINISH:
                        begin
                            if (int'(q_job.voice) < NV)
                            begin
                                held_next[q_job.voice]     = pva_pkg::NO_NOTE;
                                sounding_next[q_job.voice] = 1'b0;
                                age_next[q_job.voice]      = '0;
                            end
                        end
                        pva_pkg::OP_TICK:
                        begin
                            for (int i = 0; i < NV; i++)
                            begin
                                if (sounding_reg[i] && age_reg[i] != pva_pkg::AGE_MAX)
                                begin
                                    age_next[i] = age_reg[i] + 1'b1;
                                end
                            end
                        end
                        default:
                        begin
                            job_next        = q_job;
                            idx_next        = '0;
                            oldest_next     = '0;
                            oldest_age_next = '0;
                            pend_valid_next = 1'b0;
                            rst_mod_next    = ~playing;
                            state_next      = ST_SCAN;
                        end
                    endcase
                end
            end

            ST_SCAN:
            begin
                if (job_reg.op == pva_pkg::OP_NOTE_OFF)
                begin
                    // hold each match back a step so the final one can carry last
                    if (hit)
                    begin
                        if (pend_valid_reg)
                        begin
                            result_next.voice            = pend_reg;
                            result_next.action           = pva_pkg::ACT_RELEASE;
                            result_next.out_note         = job_reg.note;
                            result_next.out_velocity     = '0;
                            result_next.reset_modulators = 1'b0;
                            result_next.last             = 1'b0;
                            strobe_next                  = 1'b1;
                        end
                        pend_next       = idx_reg;
                        pend_valid_next = 1'b1;
                    end
                    if (at_end)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
                else if (hit || !cur_snd)
                begin
                    take_en                      = 1'b1;
                    take_idx                     = idx_reg;
                    result_next.voice            = idx_reg;
                    result_next.action           = hit ? pva_pkg::ACT_RETRIG
                                                       : pva_pkg::ACT_START;
                    result_next.out_note         = job_reg.note;
                    result_next.out_velocity     = job_reg.velocity;
                    result_next.reset_modulators = rst_mod_reg;
                    result_next.last             = 1'b1;
                    strobe_next                  = 1'b1;
                    state_next                   = ST_IDLE;
                end
                else
                begin
                    if (cur_age > oldest_age_reg)
                    begin
                        oldest_age_next = cur_age;
                        oldest_next     = idx_reg;
                    end
                    if (at_end)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end

            ST_DONE:
            begin
                result_next.out_note = job_reg.note;
                result_next.last     = 1'b1;
                strobe_next          = 1'b1;
                state_next           = ST_IDLE;
                if (job_reg.op == pva_pkg::OP_NOTE_OFF)
                begin
                    result_next.voice            = pend_valid_reg ? pend_reg : '0;
                    result_next.action           = pend_valid_reg ? pva_pkg::ACT_RELEASE
                                                                  : pva_pkg::ACT_NONE;
                    result_next.out_velocity     = '0;
                    result_next.reset_modulators = 1'b0;
                end
                else
                begin
                    take_en                      = 1'b1;
                    take_idx                     = oldest_reg;
                    result_next.voice            = oldest_reg;
                    result_next.action           = pva_pkg::ACT_STEAL;
                    result_next.out_velocity     = job_reg.velocity;
                    result_next.reset_modulators = rst_mod_reg;
                end
            end

            default: state_next = ST_IDLE;
        endcase

        if (take_en)
        begin
            held_next[take_idx]     = {1'b0, job_reg.note};
            sounding_next[take_idx] = 1'b1;
            age_next[take_idx]      = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            pend_valid_reg <= 1'b0;
            sounding_reg   <= '0;
            strobe_reg     <= 1'b0;
            for (int i = 0; i < NV; i++)
            begin
                held_reg[i] <= pva_pkg::NO_NOTE;
                age_reg[i]  <= '0;
            end
        end
        else
        begin
            state_reg      <= state_next;
            pend_valid_reg <= pend_valid_next;
            sounding_reg   <= sounding_next;
            strobe_reg     <= strobe_next;
            held_reg       <= held_next;
            age_reg        <= age_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg        <= job_next;
        idx_reg        <= idx_next;
        oldest_reg     <= oldest_next;
        oldest_age_reg <= oldest_age_next;
        pend_reg       <= pend_next;
        rst_mod_reg    <= rst_mod_next;
        result_reg     <= result_next;
    end

    `PVA_ASSERT_HOLDS(a_scan_in_range, clk, rst_n, state_reg == ST_SCAN, idx_reg <= last_idx, "scan index beyond active voices")
    `PVA_ASSERT_NEXT(a_done_returns, clk, rst_n, state_reg == ST_DONE, state_reg == ST_IDLE && strobe_reg, "done state did not emit and return")
    `PVA_ASSERT_HOLDS(a_none_is_last, clk, rst_n, strobe_reg && result_reg.action == pva_pkg::ACT_NONE, result_reg.last && result_reg.voice == '0, "empty release malformed")
    `PVA_ASSERT_HOLDS(a_taken_voice, clk, rst_n, strobe_reg && result_reg.action != pva_pkg::ACT_RELEASE && result_reg.action != pva_pkg::ACT_NONE, sounding_reg[result_reg.voice] && held_reg[result_reg.voice][pva_pkg::NOTE_W-1:0] == result_reg.out_note, "taken voice not recorded")

endmodule
